FILE: hdl/mfnt_pkg.sv
// Package for the memory file node table: field widths, request kinds,
// status codes, counter record type and parameter defaults.
// No dependencies.
package mfnt_pkg;

  localparam int KIND_W   = 3;
  localparam int NODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 8;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int FILE_BYTES_DEF = 128;

  localparam logic [KIND_W-1:0] KIND_CREATE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LINK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UNLINK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PUT    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EOF  = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] ref_cnt;
    logic [CNT_W-1:0] link_cnt;
    logic [CNT_W-1:0] length;
  } cnt_rec_t;

endpackage

FILE: hdl/memory_file_node_table.sv
// Top level of the memory file node table.
// Depends on mfnt_pkg; counters and file bytes live in two local memories.
//
// A request is taken when start is high and busy is low; busy is then high
// for one cycle while the slot's counter record and the addressed byte,
// read from the memories at acceptance, are updated and written back, and
// the result is shown with out_valid for exactly one cycle, registered from
// the busy cycle. The receiver cannot stall. The next request may be taken
// in the cycle the result is shown. The round trip through the registered
// counter memory read and its write-back sets this spacing. No clearing pass
// is run after reset: slots come up free and create clears a slot's counters.
module memory_file_node_table #(
  parameter int SLOT_COUNT = mfnt_pkg::SLOT_COUNT_DEF,
  parameter int FILE_BYTES = mfnt_pkg::FILE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [mfnt_pkg::KIND_W-1:0]    in_kind,
  input  logic [mfnt_pkg::NODE_W-1:0]    in_node_index,
  input  logic [mfnt_pkg::POS_W-1:0]     in_position,
  input  logic [mfnt_pkg::BYTE_W-1:0]    in_write_byte,
  output logic                           out_valid,
  output logic [mfnt_pkg::STATUS_W-1:0]  out_status,
  output logic [mfnt_pkg::NODE_W-1:0]    out_new_node,
  output logic [mfnt_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                           out_byte_count
);
  import mfnt_pkg::*;

  localparam int SW          = $clog2(SLOT_COUNT);
  localparam int PW          = $clog2(FILE_BYTES);
  localparam int SLOT_DEPTH  = 1 << SW;
  localparam int STORE_DEPTH = SLOT_DEPTH << PW;

  cnt_rec_t             cnt_mem [SLOT_DEPTH];
  logic [BYTE_W-1:0]    store_mem [STORE_DEPTH];

  logic                 accept;
  logic [SW-1:0]        slot_in;
  logic [PW-1:0]        off_in;
  logic                 live_in;

  logic                 busy_r;
  logic [SLOT_COUNT-1:0] use_r, use_nxt;
  logic [KIND_W-1:0]    kind_r;
  logic [SW-1:0]        slot_r;
  logic [POS_W-1:0]     pos_r;
  logic [PW-1:0]        off_r;
  logic [BYTE_W-1:0]    data_r;
  logic                 live_r;
  cnt_rec_t             cnt_q;
  logic [BYTE_W-1:0]    byte_q;

  logic                 cnt_we;
  logic [SW-1:0]        cnt_wslot;
  cnt_rec_t             cnt_wd;
  logic                 st_we;
  logic                 found;
  logic [SW-1:0]        free_idx;
  logic                 pos_eof;

  logic [STATUS_W-1:0]  status_nxt;
  logic [NODE_W-1:0]    new_node_nxt;
  logic [BYTE_W-1:0]    read_byte_nxt;
  logic                 byte_count_nxt;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [NODE_W-1:0]    out_new_node_r;
  logic [BYTE_W-1:0]    out_read_byte_r;
  logic                 out_byte_count_r;

  assign accept  = start && !busy_r;
  assign slot_in = SW'(in_node_index);
  assign off_in  = PW'(in_position);
  assign live_in = (int'(in_node_index) < SLOT_COUNT) && use_r[slot_in];
  assign pos_eof = int'(pos_r) >= FILE_BYTES - 1;

  // memories: read on accept, written back in the execute cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_q  <= cnt_mem[slot_in];
      byte_q <= store_mem[{slot_in, off_in}];
    end
    if (cnt_we) begin
      cnt_mem[cnt_wslot] <= cnt_wd;
    end
    if (st_we) begin
      store_mem[{slot_r, off_r}] <= data_r;
    end
  end

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!found && !use_r[i]) begin
        found    = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  always_comb begin
    use_nxt        = use_r;
    cnt_we         = 1'b0;
    cnt_wslot      = slot_r;
    cnt_wd         = cnt_q;
    st_we          = 1'b0;
    status_nxt     = ST_OK;
    new_node_nxt   = '0;
    read_byte_nxt  = '0;
    byte_count_nxt = 1'b0;
    if (busy_r) begin
      if (kind_r == KIND_CREATE) begin
        if (found) begin
          use_nxt[free_idx] = 1'b1;
          cnt_we            = 1'b1;
          cnt_wslot         = free_idx;
          cnt_wd            = '0;
          new_node_nxt      = NODE_W'(free_idx);
        end else begin
          status_nxt = ST_FULL;
        end
      end else if (kind_r <= KIND_READ) begin
        if (!live_r) begin
          status_nxt = ST_FREE;
        end else begin
          case (kind_r)
            KIND_LINK: begin
              cnt_we          = 1'b1;
              cnt_wd.link_cnt = cnt_q.link_cnt + 8'd1;
            end
            KIND_UNLINK: begin
              cnt_we          = 1'b1;
              cnt_wd.link_cnt = cnt_q.link_cnt - 8'd1;
              if (cnt_wd.link_cnt == '0 && cnt_q.ref_cnt == '0) begin
                use_nxt[slot_r] = 1'b0;
              end
            end
            KIND_GET: begin
              cnt_we         = 1'b1;
              cnt_wd.ref_cnt = cnt_q.ref_cnt + 8'd1;
            end
            KIND_PUT: begin
              cnt_we         = 1'b1;
              cnt_wd.ref_cnt = cnt_q.ref_cnt - 8'd1;
              if (cnt_wd.ref_cnt == '0 && cnt_q.link_cnt == '0) begin
                use_nxt[slot_r] = 1'b0;
              end
            end
            KIND_WRITE: begin
              if (pos_eof) begin
                status_nxt = ST_EOF;
              end else begin
                cnt_we         = 1'b1;
                cnt_wd.length  = {1'b0, pos_r} + 8'd1;
                st_we          = 1'b1;
                byte_count_nxt = 1'b1;
              end
            end
            KIND_READ: begin
              if (pos_eof || ({1'b0, pos_r} >= cnt_q.length)) begin
                status_nxt = ST_EOF;
              end else begin
                read_byte_nxt  = byte_q;
                byte_count_nxt = 1'b1;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      use_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= accept;
      use_r       <= use_nxt;
      out_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      slot_r <= slot_in;
      pos_r  <= in_position;
      off_r  <= off_in;
      data_r <= in_write_byte;
      live_r <= live_in;
    end
    if (busy_r) begin
      out_status_r     <= status_nxt;
      out_new_node_r   <= new_node_nxt;
      out_read_byte_r  <= read_byte_nxt;
      out_byte_count_r <= byte_count_nxt;
    end
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_new_node   = out_new_node_r;
  assign out_read_byte  = out_read_byte_r;
  assign out_byte_count = out_byte_count_r;

endmodule

FILE: hdl/mfnt_chk.sv
// Port-level checker for the memory file node table, bound to the top level.
// Depends on mfnt_pkg for widths and status codes.
module mfnt_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [mfnt_pkg::STATUS_W-1:0]  out_status,
  input logic [mfnt_pkg::NODE_W-1:0]    out_new_node,
  input logic [mfnt_pkg::BYTE_W-1:0]    out_read_byte,
  input logic                           out_byte_count
);
  import mfnt_pkg::*;

  a_result_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("request without result");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without request");

  a_error_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_byte_count == 1'b0 && out_read_byte == '0))
    else $error("byte moved on failed request");

  a_full_no_node: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_new_node == '0)
    else $error("node reported on full table");

endmodule

bind memory_file_node_table mfnt_chk u_mfnt_chk (.*);
